@@ rtl/gwm_pkg.sv @@
`default_nettype none
package gwm_pkg;

    // pattern store size used when the top level is not overridden
    localparam int MAX_PATTERN_DEF = 32;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd4;

    // special characters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // latch the incoming word
        logic char_step;  // one step of character matching
        logic verd_step;  // one step of the end-of-name check
        logic emit;       // load the result register and clear name state
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic item_empty;
        logic item_last;
        logic char_done;
        logic verd_known;
        logic out_free;
    } t_sts;

    // ascii upper case to lower case
    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/gwm_in_if.sv @@
`default_nettype none
interface gwm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_char;
    logic       last_char;
    logic       empty_name;

    modport source (output valid, output name_char, output last_char, output empty_name,
                    input ready);
    modport sink (input valid, input name_char, input last_char, input empty_name,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/gwm_out_if.sv @@
`default_nettype none
interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink (input valid, input matched, output ready);
endinterface
`default_nettype wire

@@ rtl/gwm_ctrl.sv @@
`default_nettype none
module gwm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire gwm_pkg::t_sts i_sts,
    output gwm_pkg::t_cmd      o_cmd
);
    import gwm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHAR,
        S_VERD
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    // commands follow the current state
    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && r_ready && i_in_valid;
        o_cmd.char_step = (r_state == S_CHAR) && !i_sts.item_empty;
        o_cmd.verd_step = (r_state == S_VERD) && !i_sts.verd_known;
        o_cmd.emit      = (r_state == S_VERD) && i_sts.verd_known && i_sts.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        case (r_state)
            S_IDLE: begin
                n_ready = 1'b1;
                if (r_ready && i_in_valid) begin
                    n_ready = 1'b0;
                    n_state = S_CHAR;
                end
            end
            S_CHAR: begin
                // an empty-name word skips the match step and goes to the verdict
                if (i_sts.item_empty) begin
                    n_state = S_VERD;
                end else if (i_sts.char_done) begin
                    if (i_sts.item_last) begin
                        n_state = S_VERD;
                    end else begin
                        n_state = S_IDLE;
                        n_ready = 1'b1;
                    end
                end
            end
            S_VERD: begin
                if (i_sts.verd_known && i_sts.out_free) begin
                    n_state = S_IDLE;
                    n_ready = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b0;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

endmodule
`default_nettype wire

@@ rtl/gwm_dp.sv @@
`default_nettype none
module gwm_dp #(
    parameter int MAX_PATTERN = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire gwm_pkg::t_cmd                     i_cmd,
    output gwm_pkg::t_sts                          o_sts,
    input  wire logic [7:0]                        i_name_char,
    input  wire logic                              i_last_char,
    input  wire logic                              i_empty_name,
    input  wire logic                              i_cfg_we,
    input  wire logic [gwm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gwm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_valid,
    output logic                                   o_matched,
    input  wire logic                              i_out_ready
);
    import gwm_pkg::*;

    localparam int POS_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // pattern configuration
    logic [7:0]       r_pat [MAX_PATTERN];
    logic [LEN_W-1:0] r_len;

    // latched word
    logic [7:0] r_c;
    logic       r_last, r_empty;

    // per-name state
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_wild, n_wild;
    logic             r_skip, n_skip;
    logic             r_fail, n_fail;
    logic [1:0]       r_seen, n_seen;
    logic             r_dots, n_dots;

    // result register
    logic r_out_valid, r_out_matched;

    logic [POS_W-1:0] eff_len;
    logic [7:0]       pat_cur;
    logic [7:0]       c_low;
    logic             pos_in;
    logic             verd_val;

    // configuration writes, eight bytes per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MAX_PATTERN; b++) begin
                r_pat[b] <= '0;
            end
            r_len <= '0;
        end else if (i_cfg_we) begin
            for (int b = 0; b < MAX_PATTERN; b++) begin
                if (i_cfg_index == CFG_IDX_W'(b >> 3)) begin
                    r_pat[b] <= i_cfg_data[(b & 7) * 8 +: 8];
                end
            end
            if (i_cfg_index == REG_LEN) begin
                r_len <= i_cfg_data[LEN_W-1:0];
            end
        end
    end

    // length clamped to the store size
    always_comb begin
        if (r_len > LEN_W'(MAX_PATTERN)) begin
            eff_len = POS_W'(MAX_PATTERN);
        end else begin
            eff_len = POS_W'(r_len);
        end
    end

    assign pat_cur = lower_byte(r_pat[r_pos[IDX_W-1:0]]);
    assign pos_in  = (r_pos < eff_len);
    assign c_low   = lower_byte(i_name_char);

    // end-of-name verdict and character matching
    always_comb begin
        n_pos  = r_pos;
        n_wild = r_wild;
        n_skip = r_skip;
        n_fail = r_fail;
        n_seen = r_seen;
        n_dots = r_dots;

        o_sts            = '0;
        o_sts.item_empty = r_empty;
        o_sts.item_last  = r_last;
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.char_done  = 1'b1;

        // verdict
        verd_val = 1'b0;
        if (r_fail || r_skip) begin
            o_sts.verd_known = 1'b1;
        end else if (pos_in) begin
            o_sts.verd_known = (pat_cur != CH_STAR);
        end else begin
            o_sts.verd_known = 1'b1;
            verd_val = !(r_dots && (r_seen == 2'd1 || r_seen == 2'd2));
        end

        // name statistics for the dot-name check
        if (i_cmd.accept && !i_empty_name) begin
            if (r_seen != 2'd3) begin
                n_seen = r_seen + 2'd1;
            end
            if (c_low != CH_DOT) begin
                n_dots = 1'b0;
            end
        end

        // one matching step
        if (i_cmd.char_step) begin
            if (r_fail) begin
                n_fail = 1'b1;
            end else if (r_skip) begin
                if (r_c == pat_cur) begin
                    n_skip = 1'b0;
                    n_wild = 1'b0;
                    n_pos  = r_pos + POS_W'(1);
                end
            end else if (pos_in && pat_cur == CH_STAR) begin
                n_wild          = 1'b1;
                n_pos           = r_pos + POS_W'(1);
                o_sts.char_done = 1'b0;
            end else if (!pos_in) begin
                if (!r_wild) begin
                    n_fail = 1'b1;
                end
            end else if (pat_cur == CH_QMARK || pat_cur == r_c) begin
                n_pos = r_pos + POS_W'(1);
            end else if (r_wild) begin
                n_skip = 1'b1;
            end else begin
                n_fail = 1'b1;
            end
        end

        // walk over trailing stars
        if (i_cmd.verd_step) begin
            n_pos = r_pos + POS_W'(1);
        end

        // verdict delivered, start a new name
        if (i_cmd.emit) begin
            n_pos  = '0;
            n_wild = 1'b0;
            n_skip = 1'b0;
            n_fail = 1'b0;
            n_seen = '0;
            n_dots = 1'b1;
        end
    end

    // latched word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c     <= c_low;
            r_last  <= i_last_char;
            r_empty <= i_empty_name;
        end
    end

    // name state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_wild <= 1'b0;
            r_skip <= 1'b0;
            r_fail <= 1'b0;
            r_seen <= '0;
            r_dots <= 1'b1;
        end else begin
            r_pos  <= n_pos;
            r_wild <= n_wild;
            r_skip <= n_skip;
            r_fail <= n_fail;
            r_seen <= n_seen;
            r_dots <= n_dots;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_matched <= verd_val;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_out_matched;

endmodule
`default_nettype wire

@@ rtl/greedy_wildcard_name_matcher_core.sv @@
// each word is taken in idle, then matched, with an extra step per '*' passed before
// the next literal; a final word then walks trailing '*' in the verdict state, which
// waits for a free result register; no new word is taken until these steps are done
// the result register lets the next name start while a verdict waits to be taken
// reset: synchronous active low, clears pattern, length, name state and result valid
`default_nettype none
module greedy_wildcard_name_matcher_core #(
    parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    gwm_in_if.sink                                 i_item,
    gwm_out_if.source                              o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [gwm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gwm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gwm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    gwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // pattern store, match state and result register
    gwm_dp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_name_char  (i_item.name_char),
        .i_last_char  (i_item.last_char),
        .i_empty_name (i_item.empty_name),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_result.valid),
        .o_matched    (o_result.matched),
        .i_out_ready  (o_result.ready)
    );

endmodule
`default_nettype wire

@@ rtl/gwm_checker.sv @@
`default_nettype none
module gwm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_matched
);

    // input ready is low in the cycle after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a word was taken");

    // a new verdict is only loaded while the input side is busy
    a_verdict_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("verdict appeared while input side was idle");

    // a stalled result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_matched))
        else $error("result changed while stalled");

endmodule

bind greedy_wildcard_name_matcher_core gwm_checker u_gwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_matched (o_result.matched)
);
`default_nettype wire

@@ bench/greedy_wildcard_name_matcher_core_test.sv @@
module greedy_wildcard_name_matcher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gwm_pkg::*;

    localparam int MAX_PAT       = MAX_PATTERN_DEF;
    localparam int RANDOM_WORDS  = 850;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    // expected verdicts, worked out from the pattern registers and the name bytes
    class verdict_board;
        logic [63:0] pat_regs [4];
        logic [5:0]  len_reg;
        int          pos;
        bit          star_open;
        bit          skipping;
        bit          failed;
        bit          only_dots;
        logic [1:0]  seen;
        bit          verdicts_due [$];
        int          mismatches;
        int          verdicts_checked;
        int          matches_seen;

        function new();
            foreach (pat_regs[k]) pat_regs[k] = '0;
            len_reg          = '0;
            mismatches       = 0;
            verdicts_checked = 0;
            matches_seen     = 0;
            clear_name();
        endfunction

        function void clear_name();
            pos       = 0;
            star_open = 0;
            skipping  = 0;
            failed    = 0;
            seen      = '0;
            only_dots = 1;
        endfunction

        function logic [7:0] fold_case(logic [7:0] c);
            if (c >= CH_UP_A && c <= CH_UP_Z) begin
                return c + CASE_OFS;
            end
            return c;
        endfunction

        function logic [7:0] pat_at(int i);
            logic [63:0] w;
            w = pat_regs[(i >> 3) & 3];
            return fold_case(w[(i & 7) * 8 +: 8]);
        endfunction

        function int eff_len();
            return (len_reg > MAX_PAT) ? MAX_PAT : int'(len_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PAT0: pat_regs[0] = data;
                REG_PAT1: pat_regs[1] = data;
                REG_PAT2: pat_regs[2] = data;
                REG_PAT3: pat_regs[3] = data;
                REG_LEN:  len_reg = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // one greedy match step on a lowered name byte
        function void take_byte(logic [7:0] c);
            int len;
            logic [7:0] p;
            len = eff_len();
            if (failed) return;
            if (skipping) begin
                if (c == pat_at(pos & 31)) begin
                    skipping  = 0;
                    star_open = 0;
                    pos       = (pos + 1) & 63;
                end
                return;
            end
            while (pos < len && pat_at(pos) == CH_STAR) begin
                star_open = 1;
                pos++;
            end
            if (pos >= len) begin
                if (!star_open) failed = 1;
                return;
            end
            p = pat_at(pos);
            if (p == CH_QMARK || p == c) begin
                pos++;
            end else if (star_open) begin
                skipping = 1;
            end else begin
                failed = 1;
            end
        endfunction

        function bit final_verdict();
            int len;
            len = eff_len();
            if (failed || skipping) return 0;
            for (int k = pos; k < len; k++) begin
                if (pat_at(k) != CH_STAR) return 0;
            end
            if (only_dots && (seen == 2'd1 || seen == 2'd2)) return 0;
            return 1;
        endfunction

        // accepted input word
        function void note_word(logic [7:0] c, logic last, logic empty);
            logic [7:0] lc;
            if (!empty) begin
                lc = fold_case(c);
                take_byte(lc);
                if (seen != 2'd3) seen++;
                if (lc != CH_DOT) only_dots = 0;
            end
            if (empty || last) begin
                verdicts_due.insert(verdicts_due.size(), final_verdict());
                clear_name();
            end
        endfunction

        // accepted result word
        function void check_verdict(logic got);
            bit want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict with none expected, expected none, got %0b", $time, got);
                mismatches++;
                return;
            end
            want = verdicts_due.pop_front();
            verdicts_checked++;
            if (got === 1'b1) matches_seen++;
            if (got !== want) begin
                $display("%0t: verdict mismatch, expected %0b, got %0b", $time, want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gwm_in_if  u_in ();
    gwm_out_if u_out ();

    greedy_wildcard_name_matcher_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (u_in),
        .o_result    (u_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    verdict_board board;
    logic [7:0]   name_bytes [$];
    bit           quiet;
    bit           hold_request;
    int           words_sent;
    int           pattern_settings;
    int           cycle_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // idle length, mostly zero or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        u_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && u_out.valid && u_out.ready) begin
                board.check_verdict(u_out.matched);
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                u_out.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                u_out.ready <= 1'b0;
            end else begin
                u_out.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // offer one word and wait until it is taken
    task automatic send_word(input logic [7:0] c, input logic last, input logic empty);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            u_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        u_in.valid      <= 1'b1;
        u_in.name_char  <= c;
        u_in.last_char  <= last;
        u_in.empty_name <= empty;
        do @(posedge i_clk); while (!(u_in.valid && u_in.ready));
        board.note_word(c, last, empty);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_word(s[k], k == s.len() - 1, 1'b0);
        end
    endtask

    // all verdicts in, then let the match steps run out
    task automatic wait_idle();
        u_in.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic set_pattern(input logic [255:0] pat, input logic [LEN_W-1:0] len);
        wait_idle();
        write_reg(REG_PAT0, pat[63:0]);
        write_reg(REG_PAT1, pat[127:64]);
        write_reg(REG_PAT2, pat[191:128]);
        write_reg(REG_PAT3, pat[255:192]);
        write_reg(REG_LEN, CFG_DATA_W'(len));
        i_cfg_we <= 1'b0;
        pattern_settings++;
    endtask

    function automatic logic [255:0] text_pattern(input string s);
        logic [255:0] r;
        r = '0;
        for (int k = 0; k < s.len(); k++) r[k*8 +: 8] = s[k];
        return r;
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = 8'("a") + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) c = c - CASE_OFS;
        return c;
    endfunction

    function automatic logic [7:0] pattern_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return CH_STAR;
        if (r == 3) return CH_QMARK;
        if (r < 8) return random_letter();
        if (r == 8) return CH_DOT;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] name_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return random_letter();
        if (r == 6) return CH_DOT;
        if (r == 7) return $urandom_range(0, 1) ? CH_STAR : CH_QMARK;
        return 8'($urandom_range(0, 255));
    endfunction

    // add one byte at the end of the name being built
    function automatic void append_byte(input logic [7:0] b);
        name_bytes.insert(name_bytes.size(), b);
    endfunction

    // name that mostly follows the pattern, sometimes bent or pure noise
    task automatic build_name(input logic [255:0] pat, input logic [LEN_W-1:0] len);
        int r;
        int eff;
        logic [7:0] b;
        eff = (len > MAX_PAT) ? MAX_PAT : int'(len);
        name_bytes.delete();
        r = $urandom_range(0, 19);
        if (r == 0) begin
            repeat ($urandom_range(1, 3)) append_byte(CH_DOT);
        end else if (r < 3) begin
            repeat ($urandom_range(0, 6)) append_byte(name_byte());
        end else begin
            for (int k = 0; k < eff; k++) begin
                b = pat[k*8 +: 8];
                if (b == CH_STAR) begin
                    repeat ($urandom_range(0, 3)) append_byte(name_byte());
                end else if (b == CH_QMARK) begin
                    append_byte(name_byte());
                end else begin
                    if (b >= "a" && b <= "z" && $urandom_range(0, 1)) b = b - CASE_OFS;
                    else if (b >= CH_UP_A && b <= CH_UP_Z && $urandom_range(0, 1))
                        b = b + CASE_OFS;
                    append_byte(b);
                end
            end
            // occasional damage
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 2);
                if (r == 0 && name_bytes.size() > 0)
                    name_bytes[$urandom_range(0, name_bytes.size() - 1)] = name_byte();
                else if (r == 1 && name_bytes.size() > 0)
                    void'(name_bytes.pop_back());
                else
                    append_byte(name_byte());
            end
        end
    endtask

    // name ends on its last byte or on a following empty-name word
    task automatic send_name();
        int n;
        bit via_empty;
        n = name_bytes.size();
        via_empty = (n == 0) || ($urandom_range(0, 6) == 0);
        for (int k = 0; k < n; k++) begin
            send_word(name_bytes[k], !via_empty && k == n - 1, 1'b0);
        end
        if (via_empty) begin
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    // stimulus
    initial begin
        logic [255:0]     pat;
        logic [LEN_W-1:0] len;
        int               phase;
        int               directed_words;
        int               names;
        int               r;

        board            = new();
        quiet            = 0;
        hold_request     = 0;
        words_sent       = 0;
        pattern_settings = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_PAT0;
        i_cfg_data      <= '0;
        u_in.valid      <= 1'b0;
        u_in.name_char  <= '0;
        u_in.last_char  <= 1'b0;
        u_in.empty_name <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern after reset, empty name
        send_word(8'hFF, 1'b1, 1'b1);

        // question mark, star and case folding on both sides
        set_pattern(text_pattern("A?*B"), 6'd4);
        send_text("axYb");

        // names of one or two dots never match, three dots do
        set_pattern(text_pattern("*"), 6'd1);
        send_text(".");
        send_text("..");
        send_text("...");

        // pattern used up with no star open
        set_pattern(text_pattern("a"), 6'd1);
        send_text("ab");

        // name ends in the middle of a skip
        set_pattern(text_pattern("*x"), 6'd2);
        send_text("ab");

        // trailing question mark needs a byte
        set_pattern(text_pattern("a?"), 6'd2);
        send_text("a");

        // empty-name word closes a name that already has bytes
        set_pattern(text_pattern("ab*"), 6'd3);
        send_word("a", 1'b0, 1'b0);
        send_word("B", 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);

        // zero byte literal, length above the store size
        pat = {32{CH_STAR}};
        pat[7:0] = 8'h00;
        set_pattern(pat, 6'd63);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);

        // length shortened in the middle of a name
        set_pattern(text_pattern("abc"), 6'd3);
        send_word("a", 1'b0, 1'b0);
        send_word("b", 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_LEN, CFG_DATA_W'(6'd1));
        i_cfg_we <= 1'b0;
        send_word("c", 1'b1, 1'b0);

        directed_words = words_sent;

        // random patterns, each with a batch of names
        phase = 0;
        while (words_sent < directed_words + RANDOM_WORDS) begin
            if (phase == 0) begin
                len = 6'd32;
            end else if (phase == 1) begin
                len = 6'd0;
            end else if (phase == 2) begin
                len = LEN_W'($urandom_range(33, 63));
            end else begin
                r = $urandom_range(0, 9);
                if (r == 0) len = 6'd0;
                else if (r < 7) len = LEN_W'($urandom_range(1, 8));
                else if (r == 7) len = LEN_W'($urandom_range(9, 31));
                else if (r == 8) len = 6'd32;
                else len = LEN_W'($urandom_range(33, 63));
            end
            for (int k = 0; k < 32; k++) pat[k*8 +: 8] = pattern_byte();
            quiet = ($urandom_range(0, 4) == 0);
            set_pattern(pat, len);
            names = $urandom_range(4, 16);
            // long receiver hold-off while names keep coming
            if (phase == 4) begin
                hold_request = 1;
                names = 40;
            end
            repeat (names) begin
                build_name(pat, len);
                send_name();
            end
            phase++;
        end

        // drain and finish
        wait_idle();
        $display("covered %0d words over %0d pattern settings", words_sent, pattern_settings);
        $display("checked %0d verdicts, %0d of them matches", board.verdicts_checked,
                 board.matches_seen);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
